// ===== rtl/led_blink_sequencer_power_gate_unit_defines.svh =====
// Shared assertion macros for the blink sequencer.
// Both macros sample on clk_i and are quiet while rst_ni is low.
`ifndef LED_BLINK_SEQUENCER_POWER_GATE_UNIT_DEFINES_SVH
`define LED_BLINK_SEQUENCER_POWER_GATE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBSPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LBSPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lbspg_pkg.sv =====
`default_nettype none

package lbspg_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_PIXELS  = 2;

  // Command queue between front and back end
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Register indexes
  localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_SETTLE       = 2'd1;
  localparam logic [1:0] CFG_GATE_EN      = 2'd2;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd15000;
  localparam logic [7:0]  SETTLE_RST       = 8'd10;
  localparam logic        GATE_EN_RST      = 1'b1;

  typedef enum logic [1:0] {
    KIND_PIXEL    = 2'd0,
    KIND_RAIL_ON  = 2'd1,
    KIND_RAIL_OFF = 2'd2,
    KIND_DROP     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_ON     = 3'd2,
    PH_GAP    = 3'd3
  } phase_e;

  typedef struct packed {
    logic [7:0]  led_idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  flash_cnt;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } req_t;

  typedef struct packed {
    logic is_tick;
    req_t req;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } fifo_stat_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/led_blink_sequencer_power_gate_unit.sv =====
// A transfer passes the command queue, then its result (if any) the result register.
// Throughput: one item per cycle while in_stall_o is low; a two-entry command queue and
// the result register absorb two more transfers while a result waits to be taken.
// Request queue: at most one memory write and one head read per cycle, head prefetched.
// Reset (rst_ni low, asynchronous): queues empty, rail off, timer disarmed,
// registers back to 15000 / 10 / gating on. No clearing pass is needed.
`default_nettype none

module led_blink_sequencer_power_gate_unit #(
  parameter int QueueDepth = lbspg_pkg::QUEUE_DEPTH,
  parameter int NumPixels  = lbspg_pkg::NUM_PIXELS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // register writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // item channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [7:0]  led_idx_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic [7:0]  flash_cnt_i,
  input  wire logic [15:0] on_ms_i,
  input  wire logic [15:0] off_ms_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       led_idx_res_o,
  output logic [7:0]       red_res_o,
  output logic [7:0]       green_res_o,
  output logic [7:0]       blue_res_o
);

  lbspg_pkg::cmd_t       cmd;
  logic                  cmd_valid, cmd_pop;
  logic                  push, pop;
  lbspg_pkg::req_t       wdata, head;
  lbspg_pkg::fifo_stat_t stat;
  lbspg_pkg::res_t       res;

  // Front end: take each transfer, tag it as tick or request, queue it
  lbspg_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .func_i,
    .led_idx_i,
    .red_i,
    .green_i,
    .blue_i,
    .flash_cnt_i,
    .on_ms_i,
    .off_ms_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Pending blink requests; full queue drops are decided by the back end
  lbspg_req_fifo #(
    .QueueDepth (QueueDepth)
  ) u_req_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (wdata),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (stat)
  );

  // Back end: config registers, phase sequencer, rail gating, idle timer, result register
  lbspg_back #(
    .NumPixels (NumPixels)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .push_o      (push),
    .wdata_o     (wdata),
    .pop_o       (pop),
    .head_i      (head),
    .stat_i      (stat),
    .out_valid_o,
    .out_stall_i,
    .out_o       (res)
  );

  assign kind_o        = res.kind;
  assign led_idx_res_o = res.pixel;
  assign red_res_o     = res.red;
  assign green_res_o   = res.green;
  assign blue_res_o    = res.blue;

endmodule

`default_nettype wire

// ===== rtl/lbspg_front.sv =====
`default_nettype none

module lbspg_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              func_i,
  input  wire logic [7:0]        led_idx_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  input  wire logic [7:0]        flash_cnt_i,
  input  wire logic [15:0]       on_ms_i,
  input  wire logic [15:0]       off_ms_i,
  output logic                   cmd_valid_o,
  output lbspg_pkg::cmd_t        cmd_o,
  input  wire logic              cmd_pop_i
);

  lbspg_pkg::cmd_t                  q_mem [lbspg_pkg::CMDQ_DEPTH];
  lbspg_pkg::cmd_t                  in_cmd;
  logic [lbspg_pkg::CMDQ_AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [lbspg_pkg::CMDQ_CW-1:0]    cnt_q, cnt_d;
  logic                             accept;

  // Classify: func selects tick or blink request
  always_comb begin
    in_cmd               = '0;
    in_cmd.is_tick       = func_i;
    in_cmd.req.led_idx   = led_idx_i;
    in_cmd.req.red       = red_i;
    in_cmd.req.green     = green_i;
    in_cmd.req.blue      = blue_i;
    in_cmd.req.flash_cnt = flash_cnt_i;
    in_cmd.req.on_ms     = on_ms_i;
    in_cmd.req.off_ms    = off_ms_i;
  end

  assign in_stall_o  = (cnt_q == lbspg_pkg::CMDQ_CW'(lbspg_pkg::CMDQ_DEPTH));
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (accept) begin
      wr_d = (wr_q == lbspg_pkg::CMDQ_AW'(lbspg_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_d = (rd_q == lbspg_pkg::CMDQ_AW'(lbspg_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({accept, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_q] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lbspg_req_fifo.sv =====
`default_nettype none

module lbspg_req_fifo #(
  parameter int QueueDepth = lbspg_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lbspg_pkg::req_t   wdata_i,
  input  wire logic              pop_i,
  output lbspg_pkg::req_t        head_o,
  output lbspg_pkg::fifo_stat_t  stat_o
);

  localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);

  lbspg_pkg::req_t  mem [QueueDepth];
  lbspg_pkg::req_t  head_q;
  logic [AW-1:0]    head_ptr_q, head_ptr_d, tail_q, tail_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(QueueDepth));
  assign stat_o.last  = (cnt_q == CW'(1));
  assign head_o       = head_q;

  always_comb begin
    head_ptr_d = head_ptr_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    if (pop_i) begin
      head_ptr_d = (head_ptr_q == AW'(QueueDepth - 1)) ? '0 : head_ptr_q + 1'b1;
      cnt_d      = cnt_q - 1'b1;
    end else if (push_i) begin
      tail_d = (tail_q == AW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr_q <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
    end else begin
      head_ptr_q <= head_ptr_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
    end
  end

  // Keep the head entry prefetched; bypass a write into an empty queue
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= wdata_i;
    end
    if (push_i && (tail_q == head_ptr_d)) begin
      head_q <= wdata_i;
    end else begin
      head_q <= mem[head_ptr_d];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lbspg_back.sv =====
`default_nettype none

`include "led_blink_sequencer_power_gate_unit_defines.svh"

module lbspg_back #(
  parameter int NumPixels = lbspg_pkg::NUM_PIXELS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [15:0]           cfg_data_i,
  input  wire logic                  cmd_valid_i,
  input  wire lbspg_pkg::cmd_t       cmd_i,
  output logic                       cmd_pop_o,
  output logic                       push_o,
  output lbspg_pkg::req_t            wdata_o,
  output logic                       pop_o,
  input  wire lbspg_pkg::req_t       head_i,
  input  wire lbspg_pkg::fifo_stat_t stat_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output lbspg_pkg::res_t            out_o
);

  lbspg_pkg::phase_e phase_q, phase_d;
  logic [15:0]       timer_q, timer_d;
  logic [7:0]        blinks_q, blinks_d;
  lbspg_pkg::req_t   act_q, act_d;
  logic              rail_q, rail_d;
  logic [15:0]       idle_t_q, idle_t_d;
  logic              armed_q, armed_d;
  logic [15:0]       timeout_q;
  logic [7:0]        settle_q;
  logic              gate_q;
  logic              out_valid_q, out_valid_d;
  lbspg_pkg::res_t   out_q;
  lbspg_pkg::res_t   res;
  lbspg_pkg::req_t   start_src;
  logic              do_start, do_finish, go, empty_after;

  function automatic lbspg_pkg::res_t pix_write(input lbspg_pkg::req_t src, input logic lit);
    lbspg_pkg::res_t r;
    r       = '0;
    r.kind  = lbspg_pkg::KIND_PIXEL;
    r.valid = (src.led_idx < 8'(NumPixels));
    r.pixel = src.led_idx;
    if (lit) begin
      r.red   = src.red;
      r.green = src.green;
      r.blue  = src.blue;
    end
    return r;
  endfunction

  // Take a command only when the result register is free or draining
  assign go          = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o   = go;
  assign wdata_o     = cmd_i.req;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign empty_after = pop_o ? stat_i.last : stat_i.empty;

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    blinks_d  = blinks_q;
    act_d     = act_q;
    rail_d    = rail_q;
    idle_t_d  = idle_t_q;
    armed_d   = armed_q;
    push_o    = 1'b0;
    pop_o     = 1'b0;
    do_start  = 1'b0;
    do_finish = 1'b0;
    start_src = act_q;
    res       = '0;
    res.kind  = lbspg_pkg::KIND_PIXEL;

    if (go) begin
      if (cmd_i.is_tick) begin
        if (phase_q != lbspg_pkg::PH_IDLE) begin
          if (timer_q > 16'd1) begin
            timer_d = timer_q - 16'd1;
          end else begin
            case (phase_q)
              lbspg_pkg::PH_SETTLE: begin
                do_start = 1'b1;
              end
              lbspg_pkg::PH_ON: begin
                res      = pix_write(act_q, 1'b0);
                blinks_d = blinks_q - 8'd1;
                if (blinks_q != 8'd1) begin
                  phase_d = lbspg_pkg::PH_GAP;
                  timer_d = act_q.off_ms;
                end else begin
                  do_finish = 1'b1;
                end
              end
              lbspg_pkg::PH_GAP: begin
                phase_d = lbspg_pkg::PH_ON;
                timer_d = act_q.on_ms;
                res     = pix_write(act_q, 1'b1);
              end
              default: ;
            endcase
          end
        end else if (!stat_i.empty) begin
          pop_o   = 1'b1;
          act_d   = head_i;
          armed_d = 1'b0;
          if (gate_q && !rail_q) begin
            rail_d    = 1'b1;
            phase_d   = lbspg_pkg::PH_SETTLE;
            timer_d   = {8'd0, settle_q};
            res.valid = 1'b1;
            res.kind  = lbspg_pkg::KIND_RAIL_ON;
          end else begin
            do_start  = 1'b1;
            start_src = head_i;
          end
        end else if (armed_q) begin
          if (idle_t_q > 16'd1) begin
            idle_t_d = idle_t_q - 16'd1;
          end else begin
            armed_d  = 1'b0;
            idle_t_d = '0;
            if (gate_q && rail_q) begin
              rail_d    = 1'b0;
              res.valid = 1'b1;
              res.kind  = lbspg_pkg::KIND_RAIL_OFF;
            end
          end
        end
      end else begin
        if (stat_i.full) begin
          res.valid = 1'b1;
          res.kind  = lbspg_pkg::KIND_DROP;
          res.pixel = cmd_i.req.led_idx;
        end else begin
          push_o   = 1'b1;
          armed_d  = 1'b0;
          idle_t_d = '0;
        end
      end
    end

    if (do_start) begin
      blinks_d = start_src.flash_cnt;
      if (start_src.flash_cnt == 8'd0) begin
        do_finish = 1'b1;
      end else begin
        phase_d = lbspg_pkg::PH_ON;
        timer_d = start_src.on_ms;
        res     = pix_write(start_src, 1'b1);
      end
    end

    if (do_finish) begin
      phase_d  = lbspg_pkg::PH_IDLE;
      timer_d  = '0;
      blinks_d = '0;
      if (empty_after && gate_q) begin
        armed_d  = 1'b1;
        idle_t_d = timeout_q;
      end
    end

    out_valid_d = out_valid_q;
    if (go) begin
      out_valid_d = res.valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lbspg_pkg::PH_IDLE;
      timer_q     <= '0;
      blinks_q    <= '0;
      act_q       <= '0;
      rail_q      <= 1'b0;
      idle_t_q    <= '0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= lbspg_pkg::IDLE_TIMEOUT_RST;
      settle_q    <= lbspg_pkg::SETTLE_RST;
      gate_q      <= lbspg_pkg::GATE_EN_RST;
    end else begin
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      blinks_q    <= blinks_d;
      act_q       <= act_d;
      rail_q      <= rail_d;
      idle_t_q    <= idle_t_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          lbspg_pkg::CFG_IDLE_TIMEOUT: timeout_q <= cfg_data_i;
          lbspg_pkg::CFG_SETTLE:       settle_q  <= cfg_data_i[7:0];
          lbspg_pkg::CFG_GATE_EN:      gate_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q <= res;
    end
  end

  `LBSPG_ASSERT_NXT(a_drop_when_full,
    go && !cmd_i.is_tick && stat_i.full,
    out_valid_q && (out_q.kind == lbspg_pkg::KIND_DROP), "full queue did not drop request")
  `LBSPG_ASSERT_NXT(a_rail_on_settles,
    go && res.valid && (res.kind == lbspg_pkg::KIND_RAIL_ON),
    rail_q && (phase_q == lbspg_pkg::PH_SETTLE), "rail on without settle phase")
  `LBSPG_ASSERT_NXT(a_rail_off_clean,
    go && res.valid && (res.kind == lbspg_pkg::KIND_RAIL_OFF),
    !rail_q && !armed_q, "rail off left rail or timer active")
  `LBSPG_ASSERT_IMP(a_armed_only_idle,
    armed_q,
    (phase_q == lbspg_pkg::PH_IDLE) && stat_i.empty, "idle timer armed while busy")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  // Register index that the block has no register for; writes to it must be ignored.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int STALL_LIMIT = 3000;  // cycles with no transfer before giving up
  localparam int SEG_ITEMS   = 205;   // random items per configuration segment
  localparam int NUM_SEGS    = 6;
  localparam int CMD_W       = $bits(lbspg_pkg::cmd_t);

  // One result as it leaves the block.
  typedef struct packed {
    lbspg_pkg::kind_e kind;
    logic [7:0]       pixel;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } event_t;

  // One directed row: the item, and optionally a result typed in by hand.
  typedef struct packed {
    lbspg_pkg::cmd_t cmd;
    bit              typed;
    bit              fires;
    event_t          ev;
  } row_t;

  localparam lbspg_pkg::cmd_t TICK = '{1'b1, '0};
  localparam event_t NO_EVENT = '{lbspg_pkg::KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam event_t RAIL_UP  = '{lbspg_pkg::KIND_RAIL_ON, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam event_t RAIL_DN  = '{lbspg_pkg::KIND_RAIL_OFF, 8'd0, 8'd0, 8'd0, 8'd0};

  // Run with idle timeout 2, settle 1 and gating on.
  localparam int DIR_ROWS = 22;
  localparam row_t DIRECTED [DIR_ROWS] = '{
    // tick with nothing queued right after reset: no result
    '{TICK, 1'b1, 1'b0, NO_EVENT},
    // white, one blink, zero-length phases
    '{'{1'b0, '{8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd1, 16'd0, 16'd0}}, 1'b1, 1'b0, NO_EVENT},
    '{TICK, 1'b1, 1'b1, RAIL_UP},
    '{TICK, 1'b1, 1'b1, '{lbspg_pkg::KIND_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF}},
    '{TICK, 1'b1, 1'b1, '{lbspg_pkg::KIND_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00}},
    // idle timer counts down, then drops the rail
    '{TICK, 1'b1, 1'b0, NO_EVENT},
    '{TICK, 1'b1, 1'b1, RAIL_DN},
    '{TICK, 1'b1, 1'b0, NO_EVENT},
    // zero count with the longest timings: rail comes up, nothing drawn
    '{'{1'b0, '{8'd1, 8'h00, 8'h00, 8'h00, 8'd0, 16'hFFFF, 16'hFFFF}}, 1'b1, 1'b0, NO_EVENT},
    '{TICK, 1'b1, 1'b1, RAIL_UP},
    '{TICK, 1'b0, 1'b0, NO_EVENT},
    // out-of-range pixel while the rail is already up: timing only
    '{'{1'b0, '{8'hFF, 8'h12, 8'h34, 8'h56, 8'd2, 16'd0, 16'd0}}, 1'b0, 1'b0, NO_EVENT},
    '{TICK, 1'b0, 1'b0, NO_EVENT},
    '{TICK, 1'b0, 1'b0, NO_EVENT},
    '{TICK, 1'b0, 1'b0, NO_EVENT},
    '{TICK, 1'b0, 1'b0, NO_EVENT},
    // two blinks with real on and gap lengths, rail still up
    '{'{1'b0, '{8'd1, 8'hA5, 8'h5A, 8'h3C, 8'd2, 16'd1, 16'd2}}, 1'b0, 1'b0, NO_EVENT},
    '{TICK, 1'b0, 1'b0, NO_EVENT},
    '{TICK, 1'b0, 1'b0, NO_EVENT},
    '{TICK, 1'b0, 1'b0, NO_EVENT},
    '{TICK, 1'b0, 1'b0, NO_EVENT},
    '{TICK, 1'b0, 1'b0, NO_EVENT}
  };

  // Per-segment register settings and idling mix (one mix per two segments).
  localparam logic [15:0] SEG_TIMEOUT [NUM_SEGS] = '{16'd4, 16'd0, 16'hFFFF, 16'd7, 16'd1, 16'd0};
  localparam logic [7:0]  SEG_SETTLE  [NUM_SEGS] = '{8'd2, 8'd0, 8'd0, 8'd1, 8'd3, 8'd255};
  localparam logic        SEG_GATE    [NUM_SEGS] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam int SEND_GAP_PCT   [3] = '{29, 61, 0};
  localparam int RECV_STALL_PCT [3] = '{61, 29, 0};

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [1:0]      cfg_index;
  logic [15:0]     cfg_data;
  logic            in_valid;
  logic            in_stall_o;
  lbspg_pkg::cmd_t cur_cmd;
  logic            out_valid_o;
  logic            out_stall;
  logic [1:0]      kind_o;
  logic [7:0]      pixel_res_o, red_res_o, green_res_o, blue_res_o;

  // Hand-typed expectation riding along with the current item.
  bit          row_typed;
  bit          row_fires;
  event_t      row_ev;

  int          send_gap_pct;
  int          recv_stall_pct;
  int          fail_count;

  // Predictor state: registers and the sequencer as the block should hold them.
  logic [15:0]       idle_timeout;
  logic [7:0]        settle_len;
  logic              gate_en;
  lbspg_pkg::req_t   queued_reqs[$];
  lbspg_pkg::req_t   act_req;
  lbspg_pkg::phase_e seq_phase;
  logic [15:0]       phase_left;
  logic [7:0]        blinks_rem;
  bit                rail_on;
  logic [15:0]       idle_left;
  bit                idle_live;

  event_t      due_events_q[$];

  led_blink_sequencer_power_gate_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .func_i        (cur_cmd.is_tick),
    .led_idx_i     (cur_cmd.req.led_idx),
    .red_i         (cur_cmd.req.red),
    .green_i       (cur_cmd.req.green),
    .blue_i        (cur_cmd.req.blue),
    .flash_cnt_i   (cur_cmd.req.flash_cnt),
    .on_ms_i       (cur_cmd.req.on_ms),
    .off_ms_i      (cur_cmd.req.off_ms),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .kind_o        (kind_o),
    .led_idx_res_o (pixel_res_o),
    .red_res_o     (red_res_o),
    .green_res_o   (green_res_o),
    .blue_res_o    (blue_res_o)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Write the active color (or black) to its pixel; out-of-range pixels give nothing.
  function automatic bit paint(input bit lit, output event_t ev);
    ev = '{lbspg_pkg::KIND_PIXEL, act_req.led_idx,
           lit ? act_req.red : 8'd0, lit ? act_req.green : 8'd0, lit ? act_req.blue : 8'd0};
    return act_req.led_idx < lbspg_pkg::NUM_PIXELS;
  endfunction

  // Return to idle; arm the power-down timer only once the queue is empty and gating is on.
  function automatic void end_request();
    seq_phase  = lbspg_pkg::PH_IDLE;
    phase_left = '0;
    blinks_rem = '0;
    if (queued_reqs.size() == 0 && gate_en) begin
      idle_live = 1'b1;
      idle_left = idle_timeout;
    end
  endfunction

  function automatic bit start_blinks(output event_t ev);
    ev = NO_EVENT;
    blinks_rem = act_req.flash_cnt;
    if (blinks_rem == 0) begin
      end_request();
      return 1'b0;
    end
    seq_phase  = lbspg_pkg::PH_ON;
    phase_left = act_req.on_ms;
    return paint(1'b1, ev);
  endfunction

  // Advance one millisecond: at most one phase change.
  function automatic bit advance_tick(output event_t ev);
    bit hit;
    ev = NO_EVENT;
    if (seq_phase != lbspg_pkg::PH_IDLE) begin
      if (phase_left > 1) begin
        phase_left--;
        return 1'b0;
      end
      case (seq_phase)
        lbspg_pkg::PH_SETTLE: return start_blinks(ev);
        lbspg_pkg::PH_ON: begin
          hit = paint(1'b0, ev);
          blinks_rem--;
          if (blinks_rem != 0) begin
            seq_phase  = lbspg_pkg::PH_GAP;
            phase_left = act_req.off_ms;
          end else begin
            end_request();
          end
          return hit;
        end
        default: begin
          seq_phase  = lbspg_pkg::PH_ON;
          phase_left = act_req.on_ms;
          return paint(1'b1, ev);
        end
      endcase
    end
    if (queued_reqs.size() != 0) begin
      act_req   = queued_reqs.pop_front();
      idle_live = 1'b0;
      if (gate_en && !rail_on) begin
        rail_on    = 1'b1;
        seq_phase  = lbspg_pkg::PH_SETTLE;
        phase_left = {8'd0, settle_len};
        ev         = RAIL_UP;
        return 1'b1;
      end
      return start_blinks(ev);
    end
    if (idle_live) begin
      if (idle_left > 1) begin
        idle_left--;
        return 1'b0;
      end
      idle_live = 1'b0;
      idle_left = '0;
      if (gate_en && rail_on) begin
        rail_on = 1'b0;
        ev      = RAIL_DN;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one accepted transfer; return whether it causes a result, and which.
  function automatic bit predict_blink(input lbspg_pkg::cmd_t cmd, output event_t ev);
    ev = NO_EVENT;
    if (cmd.is_tick) return advance_tick(ev);
    if (queued_reqs.size() >= lbspg_pkg::QUEUE_DEPTH) begin
      ev = '{lbspg_pkg::KIND_DROP, cmd.req.led_idx, 8'd0, 8'd0, 8'd0};
      return 1'b1;
    end
    queued_reqs.push_back(cmd.req);
    idle_live = 1'b0;
    idle_left = '0;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: check the result side first, then queue what this transfer causes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    event_t got;
    event_t want;
    event_t ev;
    bit     fires;
    string  want_s;
    string  got_s;
    if (rst_n && out_valid_o && !out_stall) begin
      got = '{lbspg_pkg::kind_e'(kind_o), pixel_res_o, red_res_o, green_res_o, blue_res_o};
      got_s = $sformatf("kind %0d pixel %0d rgb %h/%h/%h",
                        got.kind, got.pixel, got.red, got.green, got.blue);
      if (due_events_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %s", $time, got_s);
        fail_count++;
      end else begin
        want = due_events_q.pop_front();
        if (got.kind !== want.kind || got.pixel !== want.pixel || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue) begin
          want_s = $sformatf("kind %0d pixel %0d rgb %h/%h/%h",
                             want.kind, want.pixel, want.red, want.green, want.blue);
          $display("%0t: result mismatch, expected %s, got %s", $time, want_s, got_s);
          fail_count++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall_o) begin
      fires = predict_blink(cur_cmd, ev);
      // Typed rows keep the predictor in step but trust the hand-written result.
      if (row_typed) begin
        fires = row_fires;
        ev    = row_ev;
      end
      if (fires) due_events_q.push_back(ev);
    end
  end

  // Set the result stall at random at each falling edge, at the current mix.
  initial begin : result_stall
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Give up when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one item at a falling edge, with random gaps first; hold until the transfer.
  task automatic send(input lbspg_pkg::cmd_t cmd, input bit typed, input bit fires,
                      input event_t ev);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    cur_cmd   = cmd;
    row_typed = typed;
    row_fires = fires;
    row_ev    = ev;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending, wait for every expected result, then let the block go quiet.
  task automatic drain();
    in_valid = 1'b0;
    while (due_events_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      lbspg_pkg::CFG_IDLE_TIMEOUT: idle_timeout = val;
      lbspg_pkg::CFG_SETTLE:       settle_len   = val[7:0];
      lbspg_pkg::CFG_GATE_EN:      gate_en      = val[0];
      default: ;
    endcase
  endtask

  // Tick with junk in the ignored fields.
  function automatic lbspg_pkg::cmd_t random_tick();
    lbspg_pkg::cmd_t c;
    c = CMD_W'({$urandom, $urandom, $urandom});
    c.is_tick = 1'b1;
    return c;
  endfunction

  // Request: mostly short, well-formed blinks; fully random once the queue is full,
  // since such a request is dropped and its timing never runs.
  function automatic lbspg_pkg::cmd_t random_request();
    lbspg_pkg::cmd_t c;
    int              roll;
    c = CMD_W'({$urandom, $urandom, $urandom});
    c.is_tick = 1'b0;
    if (queued_reqs.size() >= lbspg_pkg::QUEUE_DEPTH) return c;
    if ($urandom_range(99) < 70) begin
      c.req.led_idx = 8'($urandom_range(lbspg_pkg::NUM_PIXELS - 1));
    end
    roll = $urandom_range(99);
    if (roll < 20)      c.req.flash_cnt = 8'd0;
    else if (roll < 85) c.req.flash_cnt = 8'($urandom_range(3, 1));
    else                c.req.flash_cnt = 8'($urandom_range(8, 4));
    // Long timings only where nothing gets drawn.
    if (c.req.flash_cnt != 0) begin
      c.req.on_ms  = ($urandom_range(99) < 70) ? 16'($urandom_range(2))
                                               : 16'($urandom_range(6, 3));
      c.req.off_ms = ($urandom_range(99) < 70) ? 16'($urandom_range(2))
                                               : 16'($urandom_range(6, 3));
    end
    return c;
  endfunction

  initial begin : stimulus
    int burst;
    int mix;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = lbspg_pkg::CFG_IDLE_TIMEOUT;
    cfg_data       = '0;
    in_valid       = 1'b0;
    cur_cmd        = '0;
    row_typed      = 1'b0;
    row_fires      = 1'b0;
    row_ev         = NO_EVENT;
    send_gap_pct   = SEND_GAP_PCT[0];
    recv_stall_pct = RECV_STALL_PCT[0];
    fail_count     = 0;
    idle_timeout   = lbspg_pkg::IDLE_TIMEOUT_RST;
    settle_len     = lbspg_pkg::SETTLE_RST;
    gate_en        = lbspg_pkg::GATE_EN_RST;
    act_req        = '0;
    seq_phase      = lbspg_pkg::PH_IDLE;
    phase_left     = '0;
    blinks_rem     = '0;
    rail_on        = 1'b0;
    idle_left      = '0;
    idle_live      = 1'b0;
    burst          = 0;

    // Hold reset, then release it at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed rows: short timers so every special case fits in a few ticks.
    write_reg(lbspg_pkg::CFG_IDLE_TIMEOUT, 16'd2);
    write_reg(lbspg_pkg::CFG_SETTLE, 16'hAB01);
    write_reg(lbspg_pkg::CFG_GATE_EN, 16'hFFF1);
    write_reg(CFG_UNUSED, 16'hFFFF);
    for (int i = 0; i < DIR_ROWS; i++) begin
      send(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].fires, DIRECTED[i].ev);
    end

    // Random segments, each under its own register setting and idling mix.
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      drain();
      mix            = seg / 2;
      send_gap_pct   = SEND_GAP_PCT[mix];
      recv_stall_pct = RECV_STALL_PCT[mix];
      // Junk in the unused upper data bits must not leak into the narrow registers.
      write_reg(lbspg_pkg::CFG_IDLE_TIMEOUT, SEG_TIMEOUT[seg]);
      write_reg(lbspg_pkg::CFG_SETTLE, {8'($urandom), SEG_SETTLE[seg]});
      write_reg(lbspg_pkg::CFG_GATE_EN, {15'($urandom), SEG_GATE[seg]});
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // Bursts of requests with no ticks fill the queue and force drops.
        if (burst == 0 && $urandom_range(99) < 3) burst = $urandom_range(22, 17);
        if (burst != 0) begin
          burst--;
          send(random_request(), 1'b0, 1'b0, NO_EVENT);
        end else if ($urandom_range(99) < (queued_reqs.size() > 6 ? 90 : 70)) begin
          send(random_tick(), 1'b0, 1'b0, NO_EVENT);
        end else begin
          send(random_request(), 1'b0, 1'b0, NO_EVENT);
        end
      end
    end

    // Wait out the last results plus the pipeline, then report.
    in_valid = 1'b0;
    while (due_events_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && due_events_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
